FILE: rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the DIV/TIMA timer: item layouts, request
// and register codes, and the tap selection of the edge-detected counter bit.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int DTT_COUNTER_BITS = 16;

  // Request kinds.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Register addresses.
  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_TIMA = 2'd1;
  localparam logic [1:0] REG_TMA  = 2'd2;
  localparam logic [1:0] REG_TAC  = 2'd3;

  localparam int         TAC_ENABLE_BIT = 2;
  localparam logic [2:0] OVERFLOW_TICKS = 3'd4;
  localparam logic [2:0] DLY_LAST       = 3'd1;

  // Counter bit watched for each TAC clock select.
  localparam logic [3:0] TAP_BIT [4] = '{4'd9, 4'd3, 4'd5, 4'd7};

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } dtt_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } dtt_out_t;

  // Level of the signal whose falling edge advances TIMA.
  function automatic logic tap_level(input logic [7:0] tac, input logic [15:0] cnt);
    logic [3:0] idx;
    idx = TAP_BIT[tac[1:0]];
    return tac[TAC_ENABLE_BIT] & cnt[idx];
  endfunction

endpackage

FILE: rtl/div_tima_timer_with_edge_detect.sv
// ----------------------------------------------------------------------------
// div_tima_timer_with_edge_detect
// DIV/TIMA/TMA/TAC timer with an input register, the single-pass update and
// a result register.
//
//   Channel  Ports                           Dir  Item
//   in       in_valid, in_stall, in_data     in   tick, register write or read
//   out      out_valid, out_stall, out_data  out  read byte and interrupt flag
//
// One item is accepted per cycle while the input channel is not stalled; its
// result passes from the input register through the update into the result
// register. The update is combinational between the input and result registers.
// Reset clears the timer registers and both valid flags.
// A stalled result holds the input register, and the input channel stalls
// only while both registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module div_tima_timer_with_edge_detect
  import dtt_pkg::*;
#(
  parameter int COUNTER_BITS = DTT_COUNTER_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dtt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dtt_out_t out_data
);

  logic     in_vld_r, out_vld_r;
  dtt_in_t  in_item_r;
  dtt_out_t out_item_r;
  dtt_out_t core_result;
  logic     advance, accept;

  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;
  assign accept   = in_valid & ~in_stall;

  dtt_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

FILE: rtl/dtt_core.sv
// ----------------------------------------------------------------------------
// dtt_core
// Timer registers and the single-pass update applied to one item: tick,
// register write or register read, with falling-edge detection on the tap.
// ----------------------------------------------------------------------------
module dtt_core
  import dtt_pkg::*;
#(
  parameter int COUNTER_BITS = DTT_COUNTER_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  dtt_in_t  item,
  output dtt_out_t result
);

  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]              tima_r, tima_nxt;
  logic [7:0]              tma_r, tma_nxt;
  logic [7:0]              tac_r, tac_nxt;
  logic [2:0]              dly_r, dly_nxt;
  logic [15:0]             cnt_ext;
  logic [7:0]              tima_inc;
  logic                    lvl_old, lvl_tick, lvl_tac, bump;

  assign cnt_inc  = cnt_r + COUNTER_BITS'(1);
  assign cnt_ext  = 16'(cnt_r);
  assign lvl_old  = tap_level(tac_r, cnt_ext);
  assign lvl_tick = tap_level(tac_r, 16'(cnt_inc));
  assign lvl_tac  = tap_level(item.write_data, cnt_ext);

  always_comb begin
    cnt_nxt  = cnt_r;
    tima_nxt = tima_r;
    tma_nxt  = tma_r;
    tac_nxt  = tac_r;
    dly_nxt  = dly_r;
    bump     = 1'b0;
    result   = '0;
    case (item.req_type)
      REQ_TICK: begin
        // The pending reload is handled before the counter moves.
        if (dly_r == DLY_LAST) begin
          dly_nxt          = '0;
          tima_nxt         = tma_r;
          result.timer_irq = 1'b1;
        end else if (dly_r > DLY_LAST) begin
          dly_nxt = dly_r - 3'd1;
        end
        cnt_nxt = cnt_inc;
        bump    = lvl_old & ~lvl_tick;
      end
      REQ_WRITE: begin
        case (item.reg_select)
          REG_DIV: begin
            bump    = lvl_old;
            cnt_nxt = '0;
          end
          REG_TIMA: begin
            tima_nxt = item.write_data;
            if (dly_r == OVERFLOW_TICKS) begin
              dly_nxt = '0;
            end
          end
          REG_TMA: begin
            tma_nxt = item.write_data;
          end
          default: begin
            tac_nxt = item.write_data;
            bump    = lvl_old & ~lvl_tac;
          end
        endcase
      end
      REQ_READ: begin
        case (item.reg_select)
          REG_DIV:  result.read_data = cnt_ext[15:8];
          REG_TIMA: result.read_data = tima_r;
          REG_TMA:  result.read_data = tma_r;
          default:  result.read_data = tac_r;
        endcase
      end
      default: begin
      end
    endcase
    // A falling edge increments TIMA; wrapping to zero starts the reload delay.
    tima_inc = tima_nxt + 8'd1;
    if (bump) begin
      tima_nxt = tima_inc;
      if (tima_inc == 8'd0) begin
        dly_nxt = OVERFLOW_TICKS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      tima_r <= '0;
      tma_r  <= '0;
      tac_r  <= '0;
      dly_r  <= '0;
    end else if (fire) begin
      cnt_r  <= cnt_nxt;
      tima_r <= tima_nxt;
      tma_r  <= tma_nxt;
      tac_r  <= tac_nxt;
      dly_r  <= dly_nxt;
    end
  end

`ifndef SYNTH
  a_dly_range: assert property (@(posedge clk) disable iff (!rst_n)
    dly_r <= OVERFLOW_TICKS)
    else $error("reload delay out of range");

  a_irq_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.timer_irq |-> item.req_type == REQ_TICK && dly_r == DLY_LAST)
    else $error("interrupt outside a final countdown tick");

  a_irq_clears_dly: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.timer_irq |=> dly_r == '0 || dly_r == OVERFLOW_TICKS)
    else $error("reload delay not finished after interrupt");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.req_type != REQ_READ |-> result.read_data == 8'd0)
    else $error("read data on a non-read item");
`endif

endmodule
